@@ hw/rtl/pc_sample_hotspot_table_assert.svh @@
// assertion macros used by the sequencing state machine of the hotspot table
`ifndef PC_SAMPLE_HOTSPOT_TABLE_ASSERT_SVH
`define PC_SAMPLE_HOTSPOT_TABLE_ASSERT_SVH

// property holds on every rising clock edge outside reset
`define PSHT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("psht assertion failed");

// when pre holds, post must hold on the next edge
`define PSHT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("psht assertion failed");

`endif

@@ hw/rtl/psht_pkg.sv @@
// shared types and constants of the hotspot table
`timescale 1ns / 1ps

package psht_pkg;

   localparam logic [1:0] OP_RECORD = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [9:0]  INC_RESET = 10'd100;
   localparam logic [10:0] RATIO_MAX = 11'd1024;
   localparam int          DIV_BITS  = 42;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] count;
      logic [10:0] ratio;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic dec_rd;
      logic dec_wr;
      logic scan;
      logic credit;
      logic bub_rd;
      logic bub_chk;
      logic rd_rd;
      logic clear;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic bub_top;
      logic bub_gt;
   } status_type;

endpackage

@@ hw/rtl/psht_channels.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps

interface psht_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] sample_pc;
   logic [4:0]  read_slot;
   modport source (output valid, output opcode, output sample_pc, output read_slot,
                   input ready);
   modport sink   (input valid, input opcode, input sample_pc, input read_slot,
                   output ready);
endinterface

interface psht_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  slot;
   logic [31:0] region_base;
   logic [31:0] entry_count;
   logic [10:0] entry_ratio;
   logic [31:0] total_hits;
   modport source (output valid, output slot, output region_base, output entry_count,
                   output entry_ratio, output total_hits, input ready);
   modport sink   (input valid, input slot, input region_base, input entry_count,
                   input entry_ratio, input total_hits, output ready);
endinterface

@@ hw/rtl/psht_div.sv @@
// restoring divider for the hit ratio, one quotient bit per cycle
`timescale 1ns / 1ps

module psht_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] count,
   input  logic [31:0] total,
   output logic [psht_pkg::DIV_BITS-1:0] quotient,
   output logic        done
);
   localparam int QW = psht_pkg::DIV_BITS;

   logic [QW-1:0] quo_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   div_ff;
   logic [5:0]    cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [32:0]   trial;
   logic          fits;

   assign trial = {rem_ff, quo_ff[QW-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= {count, 10'd0};
         rem_ff <= '0;
         div_ff <= total;
      end else if (busy_ff) begin
         // dividend bits shift out the top while quotient bits shift in
         quo_ff <= {quo_ff[QW-2:0], fits};
         rem_ff <= fits ? 32'(trial - {1'b0, div_ff}) : trial[31:0];
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

@@ hw/rtl/psht_datapath.sv @@
// table memory, scan, credit and bubble datapath
`timescale 1ns / 1ps

module psht_datapath #(
   parameter int TABLE_ENTRIES = 20,
   parameter int REGION_BYTES  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  psht_pkg::cmd_type    cmd,
   output psht_pkg::status_type stat,
   input  logic [1:0]           req_opcode,
   input  logic [31:0]          req_sample_pc,
   input  logic [4:0]           req_read_slot,
   input  logic                 csr_wr_en,
   input  logic [9:0]           csr_wr_data,
   output logic [4:0]           rsp_slot,
   output logic [31:0]          rsp_region_base,
   output logic [31:0]          rsp_entry_count,
   output logic [10:0]          rsp_entry_ratio,
   output logic [31:0]          rsp_total_hits
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam logic [AW-1:0] LastIdx  = AW'(TABLE_ENTRIES - 1);
   localparam logic [31:0]   BaseMask = ~(32'(REGION_BYTES) - 32'd1);

   psht_pkg::entry_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   psht_pkg::entry_type rd_data_ff;
   logic                rd_valid_ff;
   psht_pkg::entry_type rd_ent;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   psht_pkg::entry_type wr_data;

   logic [1:0]  op_ff, op_in;
   logic [31:0] base_ff, base_in;
   logic [4:0]  rs_ff, rs_in;
   logic [9:0]  inc_ff;
   logic [31:0] total_ff, total_in;
   logic [AW-1:0] dp_ff, dp_in;
   logic [AW:0] scan_addr_ff, scan_addr_in;
   logic        scan_tag_ff, scan_tag_in;
   logic [AW-1:0] scan_idx_ff, scan_idx_in;
   logic        free_found_ff, free_found_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [31:0] evict_ff, evict_in;
   logic [AW-1:0] idx_ff, idx_in;
   psht_pkg::entry_type cur_ff, cur_in;
   logic        div_go_ff;

   logic [4:0]  out_slot_ff;
   logic [31:0] out_base_ff, out_count_ff, out_total_ff;
   logic [10:0] out_ratio_ff;

   logic [psht_pkg::DIV_BITS-1:0] quotient;
   logic        div_done;
   logic        chk, match, is_last, gt, rs_in_range;

   psht_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .count    (cur_ff.count),
      .total    (total_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // entries never written since reset or clear read as zero
   assign rd_ent      = rd_valid_ff ? rd_data_ff : '0;
   assign chk         = cmd.scan && scan_tag_ff;
   assign match       = rd_ent.base == base_ff;
   assign is_last     = scan_idx_ff == LastIdx;
   assign gt          = cur_ff.count > rd_ent.count;
   assign rs_in_range = 32'(rs_ff) < 32'(TABLE_ENTRIES);

   assign stat.scan_done = chk && (match || is_last);
   assign stat.div_done  = div_done;
   assign stat.bub_top   = idx_ff == '0;
   assign stat.bub_gt    = gt;

   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = dp_ff;
      scan_tag_in = 1'b0;
      scan_idx_in = scan_idx_ff;
      if (cmd.dec_rd) begin
         rd_en = 1'b1;
      end else if (cmd.scan && (scan_addr_ff < (AW + 1)'(TABLE_ENTRIES))) begin
         rd_en       = 1'b1;
         rd_addr     = scan_addr_ff[AW-1:0];
         scan_tag_in = 1'b1;
         scan_idx_in = scan_addr_ff[AW-1:0];
      end else if (cmd.bub_rd) begin
         rd_en   = !stat.bub_top;
         rd_addr = idx_ff - AW'(1);
      end else if (cmd.rd_rd) begin
         rd_en   = rs_in_range;
         rd_addr = AW'(rs_ff);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = cur_ff;
      if (cmd.dec_wr) begin
         wr_en   = rd_ent.count > 32'd1;
         wr_addr = dp_ff;
         wr_data = rd_ent;
         wr_data.count = rd_ent.count - 32'd1;
      end else if (cmd.bub_rd) begin
         wr_en = stat.bub_top;
      end else if (cmd.bub_chk) begin
         wr_en = 1'b1;
         if (gt) wr_data = rd_ent;
      end
   end

   always_comb begin
      op_in         = op_ff;
      base_in       = base_ff;
      rs_in         = rs_ff;
      total_in      = total_ff;
      dp_in         = dp_ff;
      scan_addr_in  = scan_addr_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      evict_in      = evict_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      if (cmd.accept) begin
         op_in   = req_opcode;
         base_in = req_sample_pc & BaseMask;
         rs_in   = req_read_slot;
      end
      if (cmd.dec_wr) begin
         if (rd_ent.count > 32'd1) total_in = total_ff - 32'd1;
         dp_in         = (dp_ff == LastIdx) ? '0 : dp_ff + AW'(1);
         scan_addr_in  = '0;
         free_found_in = 1'b0;
         evict_in      = '0;
      end
      if (cmd.scan && rd_en) scan_addr_in = scan_addr_ff + (AW + 1)'(1);
      if (chk) begin
         if (match) begin
            idx_in       = scan_idx_ff;
            cur_in.count = rd_ent.count;
         end else if (is_last) begin
            cur_in.count = '0;
            if (free_found_ff) begin
               idx_in = free_idx_ff;
            end else begin
               // no free entry: the last one is evicted, a zero count costs nothing
               idx_in   = LastIdx;
               evict_in = rd_ent.count;
            end
         end else if (!free_found_ff && rd_ent.count == '0) begin
            free_found_in = 1'b1;
            free_idx_in   = scan_idx_ff;
         end
      end
      if (cmd.credit) begin
         cur_in.base  = base_ff;
         cur_in.count = cur_ff.count + 32'(inc_ff);
         total_in     = total_ff - evict_ff + 32'(inc_ff);
      end
      if (div_done) begin
         if (total_ff == '0)
            cur_in.ratio = '0;
         else if (quotient > psht_pkg::DIV_BITS'(psht_pkg::RATIO_MAX))
            cur_in.ratio = psht_pkg::RATIO_MAX;
         else
            cur_in.ratio = quotient[10:0];
      end
      if (cmd.bub_chk && gt) idx_in = idx_ff - AW'(1);
      if (cmd.clear) begin
         total_in = '0;
         dp_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         inc_ff    <= psht_pkg::INC_RESET;
         total_ff  <= '0;
         dp_ff     <= '0;
         div_go_ff <= 1'b0;
      end else begin
         if (cmd.clear)  valid_ff <= '0;
         else if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (csr_wr_en) inc_ff <= csr_wr_data;
         total_ff  <= total_in;
         dp_ff     <= dp_in;
         div_go_ff <= cmd.credit;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      base_ff       <= base_in;
      rs_ff         <= rs_in;
      scan_addr_ff  <= scan_addr_in;
      scan_tag_ff   <= scan_tag_in;
      scan_idx_ff   <= scan_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      evict_ff      <= evict_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         unique case (op_ff)
            psht_pkg::OP_RECORD: begin
               out_slot_ff  <= 5'(idx_ff);
               out_base_ff  <= cur_ff.base;
               out_count_ff <= cur_ff.count;
               out_ratio_ff <= cur_ff.ratio;
               out_total_ff <= total_ff;
            end
            psht_pkg::OP_READ: begin
               out_slot_ff  <= rs_ff;
               out_base_ff  <= rs_in_range ? rd_ent.base : '0;
               out_count_ff <= rs_in_range ? rd_ent.count : '0;
               out_ratio_ff <= rs_in_range ? rd_ent.ratio : '0;
               out_total_ff <= total_ff;
            end
            default: begin
               out_slot_ff  <= '0;
               out_base_ff  <= '0;
               out_count_ff <= '0;
               out_ratio_ff <= '0;
               out_total_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_slot        = out_slot_ff;
   assign rsp_region_base = out_base_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_entry_ratio = out_ratio_ff;
   assign rsp_total_hits  = out_total_ff;
endmodule

@@ hw/rtl/psht_ctrl.sv @@
// sequencing state machine of the hotspot table
`timescale 1ns / 1ps
`include "pc_sample_hotspot_table_assert.svh"

module psht_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_opcode,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output psht_pkg::cmd_type    cmd,
   input  psht_pkg::status_type stat
);
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DEC_RD  = 4'd1;
   localparam logic [3:0] S_DEC_WR  = 4'd2;
   localparam logic [3:0] S_SCAN    = 4'd3;
   localparam logic [3:0] S_CREDIT  = 4'd4;
   localparam logic [3:0] S_DIV     = 4'd5;
   localparam logic [3:0] S_BUB_RD  = 4'd6;
   localparam logic [3:0] S_BUB_CHK = 4'd7;
   localparam logic [3:0] S_RD_RD   = 4'd8;
   localparam logic [3:0] S_CLR     = 4'd9;
   localparam logic [3:0] S_FINISH  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               priority case (req_opcode)
                  psht_pkg::OP_RECORD: state_in = S_DEC_RD;
                  psht_pkg::OP_READ:   state_in = S_RD_RD;
                  psht_pkg::OP_CLEAR:  state_in = S_CLR;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_DEC_RD: begin
            cmd.dec_rd = 1'b1;
            state_in   = S_DEC_WR;
         end
         S_DEC_WR: begin
            cmd.dec_wr = 1'b1;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_CREDIT;
         end
         S_CREDIT: begin
            cmd.credit = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_BUB_RD;
         end
         S_BUB_RD: begin
            cmd.bub_rd = 1'b1;
            state_in   = stat.bub_top ? S_FINISH : S_BUB_CHK;
         end
         S_BUB_CHK: begin
            cmd.bub_chk = 1'b1;
            state_in    = stat.bub_gt ? S_BUB_RD : S_FINISH;
         end
         S_RD_RD: begin
            cmd.rd_rd = 1'b1;
            state_in  = S_FINISH;
         end
         S_CLR: begin
            cmd.clear = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PSHT_ASSERT(a_word_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
   `PSHT_ASSERT_NEXT(a_div_to_bubble, clock, reset, state_ff == S_DIV && stat.div_done, state_ff == S_BUB_RD)
   `PSHT_ASSERT_NEXT(a_emit_done, clock, reset, cmd.emit, state_ff == S_IDLE && rsp_valid_ff)
endmodule

@@ hw/rtl/pc_sample_hotspot_table.sv @@
// top level of the program-counter hotspot table
`timescale 1ns / 1ps

// Hotspot table of sampled program-counter regions, in which a credited entry moves up
// past entries with a lower hit count. One word is worked on at a time and each gives
// one response word (opcode 3 gives none). A record runs a decay read-modify-write, a
// serial scan of the table memory at one entry per cycle, a credit step, the 42-step
// restoring divider with its start and done strobes, and a bubble pass that reads and
// checks each position moved through the single read port, before its response is
// registered. A read or a clear passes through its own state and the finish state. A
// response not yet taken holds the block in its last state. A clear or reset empties
// the table at once through per-entry valid bits. The hit increment may be written on
// the csr port while the block is idle.
module pc_sample_hotspot_table #(
   parameter int TABLE_ENTRIES = 20,
   parameter int REGION_BYTES  = 16
) (
   input  logic        clock,
   input  logic        reset,
   psht_req_if.sink    req,
   psht_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);
   psht_pkg::cmd_type    cmd;
   psht_pkg::status_type stat;

   psht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   psht_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .REGION_BYTES  (REGION_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req.opcode),
      .req_sample_pc   (req.sample_pc),
      .req_read_slot   (req.read_slot),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_slot        (rsp.slot),
      .rsp_region_base (rsp.region_base),
      .rsp_entry_count (rsp.entry_count),
      .rsp_entry_ratio (rsp.entry_ratio),
      .rsp_total_hits  (rsp.total_hits)
   );
endmodule

@@ test/testbench.sv @@
// testbench of the program-counter hotspot table: scoreboard class and directed/random drive
`timescale 1ns / 1ps

class hotspot_scoreboard;
   typedef struct packed {
      logic [4:0]  slot;
      logic [31:0] base;
      logic [31:0] count;
      logic [10:0] ratio;
      logic [31:0] total;
   } outcome_type;

   localparam int N_ENTRIES = 20;
   logic [31:0] bases[N_ENTRIES];
   logic [31:0] counts[N_ENTRIES];
   logic [10:0] ratios[N_ENTRIES];
   int unsigned decay_idx;
   logic [31:0] total;
   logic [9:0]  increment;
   outcome_type pending[$];
   int errors;
   int n_results;

   function new();
      wipe();
      increment = psht_pkg::INC_RESET;
      errors = 0;
      n_results = 0;
   endfunction

   function void wipe();
      for (int i = 0; i < N_ENTRIES; i++) begin
         bases[i] = '0;
         counts[i] = '0;
         ratios[i] = '0;
      end
      decay_idx = 0;
      total = '0;
   endfunction

   function void swap(int a, int b);
      logic [31:0] tb;
      logic [31:0] tc;
      logic [10:0] tr;
      tb = bases[a]; bases[a] = bases[b]; bases[b] = tb;
      tc = counts[a]; counts[a] = counts[b]; counts[b] = tc;
      tr = ratios[a]; ratios[a] = ratios[b]; ratios[b] = tr;
   endfunction

   function int credit(int idx, logic [31:0] base);
      logic [63:0] q;
      bases[idx] = base;
      total = total + 32'(increment);
      counts[idx] = counts[idx] + 32'(increment);
      if (total == 0) begin
         q = 0;
      end else begin
         q = {22'd0, counts[idx], 10'd0} / {32'd0, total};
         if (q > 64'(psht_pkg::RATIO_MAX)) q = 64'(psht_pkg::RATIO_MAX);
      end
      ratios[idx] = q[10:0];
      while (idx > 0 && counts[idx] > counts[idx-1]) begin
         swap(idx, idx - 1);
         idx--;
      end
      return idx;
   endfunction

   function int record(logic [31:0] pc);
      logic [31:0] base;
      int free_idx;
      base = pc & ~32'd15;
      free_idx = N_ENTRIES;
      if (counts[decay_idx] > 1) begin
         counts[decay_idx]--;
         total--;
      end
      decay_idx = (decay_idx + 1) % N_ENTRIES;
      for (int i = 0; i < N_ENTRIES; i++) begin
         if (bases[i] == base) return credit(i, base);
         if (free_idx == N_ENTRIES && counts[i] == 0) free_idx = i;
      end
      if (free_idx < N_ENTRIES) return credit(free_idx, base);
      total = total - counts[N_ENTRIES-1];
      counts[N_ENTRIES-1] = 0;
      return credit(N_ENTRIES - 1, base);
   endfunction

   // notes one accepted request word
   function void note_request(logic [1:0] op, logic [31:0] pc, logic [4:0] rs);
      outcome_type o;
      int p;
      if (op == psht_pkg::OP_RECORD) begin
         p = record(pc);
         o = '{p[4:0], bases[p], counts[p], ratios[p], total};
         pending.push_back(o);
      end else if (op == psht_pkg::OP_READ) begin
         if (rs < N_ENTRIES) o = '{rs, bases[rs], counts[rs], ratios[rs], total};
         else o = '{rs, 32'd0, 32'd0, 11'd0, total};
         pending.push_back(o);
      end else if (op == psht_pkg::OP_CLEAR) begin
         wipe();
         pending.push_back('0);
      end
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   task check_response(outcome_type got);
      outcome_type e;
      n_results++;
      if (pending.size() == 0) begin
         report("response word with nothing expected");
         return;
      end
      e = pending.pop_front();
      if (got.slot !== e.slot) report($sformatf("slot %0d, want %0d", got.slot, e.slot));
      if (got.base !== e.base) report($sformatf("base %h, want %h", got.base, e.base));
      if (got.count !== e.count)
         report($sformatf("count %0d, want %0d", got.count, e.count));
      if (got.ratio !== e.ratio)
         report($sformatf("ratio %0d, want %0d", got.ratio, e.ratio));
      if (got.total !== e.total)
         report($sformatf("total %0d, want %0d", got.total, e.total));
   endtask
endclass

module testbench;
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [9:0] csr_wr_data = '0;
   int         send_idle = 0;
   int         recv_idle = 0;
   int         n_sent = 0;
   logic [31:0] hot_pcs[8];

   psht_req_if req ();
   psht_rsp_if rsp ();
   hotspot_scoreboard sb = new();

   pc_sample_hotspot_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req.sink),
      .rsp        (rsp.source),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.opcode = psht_pkg::OP_RECORD;
      req.sample_pc = '0;
      req.read_slot = '0;
      rsp.ready = 1'b0;
   end

   // receiver: ready changes on the falling edge, words taken on the rising edge
   always @(negedge clock) begin
      if (!reset) rsp.ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_response({rsp.slot, rsp.region_base, rsp.entry_count, rsp.entry_ratio,
                            rsp.total_hits});
   end

   // valid stays up after an accepted word until the next word or an idle cycle
   task send_word(logic [1:0] op, logic [31:0] pc, logic [4:0] rs);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.sample_pc <= pc;
      req.read_slot <= rs;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_request(op, pc, rs);
      n_sent++;
      @(negedge clock);
   endtask

   task drain();
      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      // an unused opcode may still be in flight
      repeat (10) @(negedge clock);
   endtask

   task write_increment(logic [9:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.increment = v;
   endtask

   task random_word();
      int r;
      logic [31:0] pc;
      r = $urandom_range(99);
      if (r < 60) begin
         pc = hot_pcs[$urandom_range(7)] + $urandom_range(63);
         send_word(psht_pkg::OP_RECORD, pc, 5'($urandom));
      end else if (r < 78) begin
         send_word(psht_pkg::OP_RECORD, $urandom, 5'($urandom));
      end else if (r < 92) begin
         send_word(psht_pkg::OP_READ, $urandom, 5'($urandom_range(19)));
      end else if (r < 96) begin
         send_word(psht_pkg::OP_READ, $urandom, 5'($urandom_range(31)));
      end else if (r < 98) begin
         send_word(psht_pkg::OP_CLEAR, $urandom, 5'($urandom));
      end else begin
         send_word(psht_pkg::OP_UNUSED, $urandom, 5'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++) hot_pcs[i] = $urandom & ~32'd63;

      // directed: region zero on an empty table, extremes, reads, clear, unused opcode
      send_word(psht_pkg::OP_RECORD, 32'h0000_0000, 5'd0);
      send_word(psht_pkg::OP_RECORD, 32'h0000_000F, 5'd31);
      send_word(psht_pkg::OP_RECORD, 32'hFFFF_FFFF, 5'd0);
      send_word(psht_pkg::OP_RECORD, 32'hFFFF_FFF0, 5'd0);
      send_word(psht_pkg::OP_RECORD, 32'h5555_5555, 5'd0);
      send_word(psht_pkg::OP_RECORD, 32'hAAAA_AAAA, 5'd0);
      send_word(psht_pkg::OP_READ, 32'hFFFF_FFFF, 5'd0);
      send_word(psht_pkg::OP_READ, 32'h0, 5'd19);
      send_word(psht_pkg::OP_READ, 32'h0, 5'd20);
      send_word(psht_pkg::OP_READ, 32'h0, 5'd31);
      send_word(psht_pkg::OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
      send_word(psht_pkg::OP_CLEAR, 32'h0, 5'd0);
      send_word(psht_pkg::OP_READ, 32'h0, 5'd1);
      write_increment(10'd1023);
      // fill past the table so the last entry is evicted
      for (int i = 0; i < 22; i++) send_word(psht_pkg::OP_RECORD, i * 32'h100, 5'd0);
      write_increment(10'd1);
      send_word(psht_pkg::OP_RECORD, 32'h1234_5678, 5'd0);
      send_word(psht_pkg::OP_READ, 32'h0, 5'd19);

      send_idle = 28; recv_idle = 80;
      for (int i = 0; i < 500; i++) begin
         if (i == 250) write_increment(10'd100);
         random_word();
      end
      drain(); // sender holds off until every response is back
      write_increment(10'd1023);
      send_idle = 80; recv_idle = 28;
      for (int i = 0; i < 500; i++) begin
         if (i == 250) write_increment(10'($urandom_range(1, 1023)));
         random_word();
      end
      write_increment(10'd1);
      send_idle = 0; recv_idle = 0;
      for (int i = 0; i < 600; i++) begin
         if (i == 300) write_increment(10'($urandom_range(1, 1023)));
         random_word();
      end
      drain();
      repeat (100) @(negedge clock);
      $display("%0d request words sent, %0d response words checked across several increments",
               n_sent, sb.n_results);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/psht_pkg.sv
hw/rtl/psht_channels.sv
hw/rtl/psht_div.sv
hw/rtl/psht_datapath.sv
hw/rtl/psht_ctrl.sv
hw/rtl/pc_sample_hotspot_table.sv
test/testbench.sv
